### hw/rtl/qst_pkg.sv
// Shared types and sizes for the query statistics table.
// Holds the request/response words, cell and log control structs and opcodes.
// No dependencies.
package qst_pkg;

   localparam int LOG_DEPTH    = 128;
   localparam int CLIENT_SLOTS = 16;

   localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int LOG_CW    = $clog2(LOG_DEPTH + 1);
   localparam int LOG_SW    = LOG_CW + 1;
   localparam int CLIENT_IW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int CLIENT_CW = $clog2(CLIENT_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_RECORD      = 2'd0,
      OP_READ_CLIENT = 2'd1,
      OP_READ_LOG    = 2'd2,
      OP_CLEAR       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_ALLOWED = 2'd0,
      ACT_BLOCKED = 2'd1,
      ACT_CACHED  = 2'd2,
      ACT_ERROR   = 2'd3
   } action_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] client_ip;
      action_type  action;
      logic [15:0] response_ms;
      logic [31:0] timestamp_ms;
      logic [6:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] entry_ip;
      logic [31:0] entry_queries;
      action_type  entry_action;
      logic [31:0] entry_time;
      logic [15:0] entry_response;
      logic [31:0] total_queries;
      logic [31:0] blocked_queries;
      logic [31:0] allowed_queries;
      logic [31:0] cached_queries;
      logic [31:0] failed_queries;
      logic [7:0]  fill_level;
   } rsp_type;

   typedef struct packed {
      logic                 record;
      logic [31:0]          ip;
      logic                 any_match;
      logic [CLIENT_CW-1:0] clients_used;
      logic [6:0]           read_index;
   } cell_ctl_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] rd_ip;
      logic [31:0] rd_hits;
   } cell_chain_type;

   typedef struct packed {
      logic        write;
      logic        clear;
      logic        read;
      logic [31:0] ip;
      action_type  action;
      logic [15:0] response;
      logic [31:0] time_ms;
      logic [6:0]  index;
   } log_ctl_type;

   typedef struct packed {
      logic [31:0] ip;
      action_type  action;
      logic [31:0] time_ms;
      logic [15:0] response;
   } log_entry_type;

   typedef struct packed {
      logic          valid;
      log_entry_type entry;
   } log_rd_type;

endpackage

### hw/rtl/qst_cell.sv
// One client slot of the client table row: address and hit count.
// Passes the match flag and the read data on to the next cell. Uses qst_pkg.
module qst_cell
   import qst_pkg::*;
(
   input  logic                 clock,
   input  logic [CLIENT_IW-1:0] cell_id,
   input  cell_ctl_type         ctl,
   input  cell_chain_type       chain_in,
   output cell_chain_type       chain_out
);

   logic [31:0] addr_ff, addr_in;
   logic [31:0] hits_ff, hits_in;
   logic        used;
   logic        my_hit;
   logic        alloc;
   logic        sel;

   assign used   = 32'(cell_id) < 32'(ctl.clients_used);
   assign my_hit = used && (addr_ff == ctl.ip);
   assign alloc  = ctl.record && !ctl.any_match && (32'(cell_id) == 32'(ctl.clients_used));
   assign sel    = 32'(ctl.read_index) == 32'(cell_id);

   always_comb begin
      addr_in = addr_ff;
      hits_in = hits_ff;
      if (ctl.record && my_hit) begin
         hits_in = hits_ff + 32'd1;
      end else if (alloc) begin
         addr_in = ctl.ip;
         hits_in = 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hits_ff <= hits_in;
   end

   always_comb begin
      chain_out.hit     = chain_in.hit | my_hit;
      chain_out.rd_ip   = sel ? addr_ff : chain_in.rd_ip;
      chain_out.rd_hits = sel ? hits_ff : chain_in.rd_hits;
   end

endmodule

### hw/rtl/qst_log.sv
// Ring log of recorded queries: memory, write pointer and fill count.
// Read index counts from the oldest entry; read data is registered. Uses qst_pkg.
module qst_log
   import qst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  log_ctl_type       ctl,
   output log_rd_type        rd,
   output logic [LOG_CW-1:0] used
);

   log_entry_type mem [LOG_DEPTH];

   logic [LOG_AW-1:0] wptr_ff, wptr_in;
   logic [LOG_CW-1:0] used_ff, used_in;
   log_entry_type     rd_data_ff;
   logic              rd_valid_ff;
   logic [LOG_SW-1:0] sum;
   logic [LOG_SW-1:0] wrapped;
   logic [LOG_AW-1:0] phys;
   log_entry_type     wr_entry;

   always_comb begin
      sum = LOG_SW'(wptr_ff) + LOG_SW'(LOG_DEPTH) - LOG_SW'(used_ff) + LOG_SW'(ctl.index);
      wrapped = (sum >= LOG_SW'(LOG_DEPTH)) ? sum - LOG_SW'(LOG_DEPTH) : sum;
      phys = wrapped[LOG_AW-1:0];
   end

   always_comb begin
      wr_entry.ip       = ctl.ip;
      wr_entry.action   = ctl.action;
      wr_entry.time_ms  = ctl.time_ms;
      wr_entry.response = ctl.response;
   end

   always_comb begin
      wptr_in = wptr_ff;
      used_in = used_ff;
      if (ctl.clear) begin
         wptr_in = '0;
         used_in = '0;
      end else if (ctl.write) begin
         wptr_in = (wptr_ff == LOG_AW'(LOG_DEPTH - 1)) ? '0 : wptr_ff + LOG_AW'(1);
         if (used_ff != LOG_CW'(LOG_DEPTH)) begin
            used_in = used_ff + LOG_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         used_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mem[wptr_ff] <= wr_entry;
      end
      if (ctl.read) begin
         rd_data_ff  <= mem[phys];
         rd_valid_ff <= 32'(ctl.index) < 32'(used_ff);
      end
   end

   assign rd.valid = rd_valid_ff;
   assign rd.entry = rd_data_ff;
   assign used     = used_ff;

endmodule

### hw/rtl/query_stats_table.sv
// Top level of the query statistics table: counters, client cell row, ring log.
// Depends on qst_pkg, qst_cell and qst_log.
//
// A word is accepted when start is high and busy is low. Every word passes
// through ST_EXEC, in which the client cell row, the counters and the log
// memory are updated or read, and then ST_RESP, in which the response is
// shown on rsp_word with rsp_strobe high in that state; the log memory's
// read port is registered, so its data reaches rsp_word in ST_RESP. busy is
// low in ST_RESP, so a new word may be accepted while the last response is
// shown. The receiver cannot stall: a response must be taken in its strobe
// cycle. No clearing pass follows reset; the block is ready once reset ends.
module query_stats_table
   import qst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic      accept;

   logic [31:0] total_ff, total_in;
   logic [31:0] blocked_ff, blocked_in;
   logic [31:0] allowed_ff, allowed_in;
   logic [31:0] cached_ff, cached_in;
   logic [31:0] failed_ff, failed_in;

   logic [CLIENT_CW-1:0] clients_ff, clients_in;
   logic                 crd_valid_ff;
   logic [31:0]          crd_ip_ff;
   logic [31:0]          crd_hits_ff;

   logic           do_record;
   logic           do_clear;
   cell_ctl_type   cell_ctl;
   cell_chain_type chain [CLIENT_SLOTS+1];
   log_ctl_type    log_ctl;
   log_rd_type     log_rd;
   logic [LOG_CW-1:0] log_used;
   logic [31:0]    fill_wide;

   assign busy      = (state_ff == ST_EXEC);
   assign accept    = start && !busy;
   assign do_record = (state_ff == ST_EXEC) && (req_ff.opcode == OP_RECORD);
   assign do_clear  = (state_ff == ST_EXEC) && (req_ff.opcode == OP_CLEAR);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
   end

   // client cell row
   assign chain[0] = '0;

   always_comb begin
      cell_ctl.record       = do_record;
      cell_ctl.ip           = req_ff.client_ip;
      cell_ctl.any_match    = chain[CLIENT_SLOTS].hit;
      cell_ctl.clients_used = clients_ff;
      cell_ctl.read_index   = req_ff.entry_index;
   end

   for (genvar i = 0; i < CLIENT_SLOTS; i++) begin : g_cell
      qst_cell u_cell (
         .clock     (clock),
         .cell_id   (CLIENT_IW'(i)),
         .ctl       (cell_ctl),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   always_comb begin
      clients_in = clients_ff;
      if (do_clear) begin
         clients_in = '0;
      end else if (do_record && !chain[CLIENT_SLOTS].hit &&
                   (clients_ff != CLIENT_CW'(CLIENT_SLOTS))) begin
         clients_in = clients_ff + CLIENT_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clients_ff <= '0;
      end else begin
         clients_ff <= clients_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         crd_valid_ff <= 32'(req_ff.entry_index) < 32'(clients_ff);
         crd_ip_ff    <= chain[CLIENT_SLOTS].rd_ip;
         crd_hits_ff  <= chain[CLIENT_SLOTS].rd_hits;
      end
   end

   // ring log
   always_comb begin
      log_ctl.write    = do_record;
      log_ctl.clear    = do_clear;
      log_ctl.read     = (state_ff == ST_EXEC) && (req_ff.opcode == OP_READ_LOG);
      log_ctl.ip       = req_ff.client_ip;
      log_ctl.action   = req_ff.action;
      log_ctl.response = req_ff.response_ms;
      log_ctl.time_ms  = req_ff.timestamp_ms;
      log_ctl.index    = req_ff.entry_index;
   end

   qst_log u_log (
      .clock (clock),
      .reset (reset),
      .ctl   (log_ctl),
      .rd    (log_rd),
      .used  (log_used)
   );

   // counters
   always_comb begin
      total_in   = total_ff;
      blocked_in = blocked_ff;
      allowed_in = allowed_ff;
      cached_in  = cached_ff;
      failed_in  = failed_ff;
      if (do_clear) begin
         total_in   = '0;
         blocked_in = '0;
         allowed_in = '0;
         cached_in  = '0;
         failed_in  = '0;
      end else if (do_record) begin
         total_in = total_ff + 32'd1;
         case (req_ff.action)
            ACT_ALLOWED: allowed_in = allowed_ff + 32'd1;
            ACT_BLOCKED: blocked_in = blocked_ff + 32'd1;
            ACT_CACHED:  cached_in  = cached_ff + 32'd1;
            default:     failed_in  = failed_ff + 32'd1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         blocked_ff <= '0;
         allowed_ff <= '0;
         cached_ff  <= '0;
         failed_ff  <= '0;
      end else begin
         total_ff   <= total_in;
         blocked_ff <= blocked_in;
         allowed_ff <= allowed_in;
         cached_ff  <= cached_in;
         failed_ff  <= failed_in;
      end
   end

   // response word
   assign rsp_strobe = (state_ff == ST_RESP);

   always_comb begin
      rsp_word = '0;
      rsp_word.total_queries   = total_ff;
      rsp_word.blocked_queries = blocked_ff;
      rsp_word.allowed_queries = allowed_ff;
      rsp_word.cached_queries  = cached_ff;
      rsp_word.failed_queries  = failed_ff;
      fill_wide = 32'(log_used);
      case (req_ff.opcode)
         OP_READ_CLIENT: begin
            fill_wide = 32'(clients_ff);
            if (crd_valid_ff) begin
               rsp_word.entry_valid   = 1'b1;
               rsp_word.entry_ip      = crd_ip_ff;
               rsp_word.entry_queries = crd_hits_ff;
            end
         end
         OP_READ_LOG: begin
            if (log_rd.valid) begin
               rsp_word.entry_valid    = 1'b1;
               rsp_word.entry_ip       = log_rd.entry.ip;
               rsp_word.entry_action   = log_rd.entry.action;
               rsp_word.entry_time     = log_rd.entry.time_ms;
               rsp_word.entry_response = log_rd.entry.response;
            end
         end
         default: begin
         end
      endcase
      rsp_word.fill_level = fill_wide[7:0];
   end

endmodule
